// ===== design/lned_pkg.sv =====
// Shared types, constants and microprogram table of the terminal line editor.
`default_nettype none

package lned_pkg;

   // Default line store depth
   localparam int LINE_SIZE_DEF = 32;

   // Microprogram counter width and configuration port sizes
   localparam int PC_W       = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_MODE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOTE_ECHO = 1'd1;

   // Character codes
   localparam logic [6:0] KEY_BS     = 7'd8;
   localparam logic [6:0] KEY_LF     = 7'd10;
   localparam logic [6:0] KEY_CR     = 7'd13;
   localparam logic [6:0] KEY_CTRL_R = 7'd18;
   localparam logic [6:0] KEY_CTRL_U = 7'd21;
   localparam logic [6:0] KEY_DEL    = 7'h7f;
   localparam logic [7:0] CHR_BS     = 8'h08;
   localparam logic [7:0] CHR_LF     = 8'h0a;
   localparam logic [7:0] CHR_CR     = 8'h0d;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_CARET  = 8'h5e;
   localparam logic [7:0] CHR_U      = 8'h55;
   localparam logic [7:0] CHR_R      = 8'h52;

   // Microprogram step addresses
   localparam logic [PC_W-1:0] STEP_IDLE  = 5'd0;
   localparam logic [PC_W-1:0] STEP_RAW   = 5'd1;
   localparam logic [PC_W-1:0] STEP_KILL  = 5'd2;
   localparam logic [PC_W-1:0] STEP_KILL1 = 5'd3;
   localparam logic [PC_W-1:0] STEP_KILL2 = 5'd4;
   localparam logic [PC_W-1:0] STEP_KILL3 = 5'd5;
   localparam logic [PC_W-1:0] STEP_RTYP  = 5'd6;
   localparam logic [PC_W-1:0] STEP_RTYP1 = 5'd7;
   localparam logic [PC_W-1:0] STEP_RTYP2 = 5'd8;
   localparam logic [PC_W-1:0] STEP_RTYP3 = 5'd9;
   localparam logic [PC_W-1:0] STEP_RRD   = 5'd10;
   localparam logic [PC_W-1:0] STEP_REMIT = 5'd11;
   localparam logic [PC_W-1:0] STEP_ERS   = 5'd12;
   localparam logic [PC_W-1:0] STEP_ERS1  = 5'd13;
   localparam logic [PC_W-1:0] STEP_ERS2  = 5'd14;
   localparam logic [PC_W-1:0] STEP_NL    = 5'd15;
   localparam logic [PC_W-1:0] STEP_NL1   = 5'd16;
   localparam logic [PC_W-1:0] STEP_OTHER = 5'd17;
   localparam logic [PC_W-1:0] STEP_STORE = 5'd18;
   localparam logic [PC_W-1:0] STEP_FRD   = 5'd19;
   localparam logic [PC_W-1:0] STEP_FEMIT = 5'd20;
   localparam logic [PC_W-1:0] STEP_FCLR  = 5'd21;
   localparam logic [PC_W-1:0] STEP_FIN   = 5'd22;

   // Control word field codes
   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_GOTO,
      JMP_COND,
      JMP_DISPATCH
   } jmp_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_IDX_EQ_LEN,
      COND_RDATA_NZ,
      COND_NO_FLUSH
   } cond_type;

   typedef enum logic {
      GATE_ALWAYS,
      GATE_TAKEN
   } gate_type;

   typedef enum logic [1:0] {
      SRC_LIT,
      SRC_CHAR,
      SRC_RDATA
   } src_type;

   typedef enum logic [1:0] {
      LEN_KEEP,
      LEN_CLEAR,
      LEN_INC,
      LEN_DEC
   } len_op_type;

   typedef enum logic [1:0] {
      IDX_KEEP,
      IDX_CLEAR,
      IDX_INC
   } idx_op_type;

   // One microprogram word
   typedef struct packed {
      jmp_type          jmp;
      cond_type         cond;
      gate_type         gate;
      logic [PC_W-1:0]  target;
      logic             emit;
      src_type          src;
      logic             sess;
      logic [7:0]       lit;
      len_op_type       len_op;
      idx_op_type       idx_op;
      logic             mem_wr;
      logic             fin;
   } uword_type;

   // Datapath controls for the current cycle
   typedef struct packed {
      logic             load_char;
      logic             emit;
      src_type          src;
      logic             sess;
      logic [7:0]       lit;
      len_op_type       len_op;
      idx_op_type       idx_op;
      logic             mem_wr;
      logic             fin;
   } ctl_type;

   // Datapath flags seen by the sequencer
   typedef struct packed {
      logic idx_eq_len;
      logic rdata_nz;
      logic no_flush;
      logic line_empty;
      logic raw_mode;
      logic remote_echo;
   } status_type;

   localparam uword_type UW_NOP = '{
      jmp:    JMP_NEXT,
      cond:   COND_NONE,
      gate:   GATE_ALWAYS,
      target: STEP_IDLE,
      emit:   1'b0,
      src:    SRC_LIT,
      sess:   1'b0,
      lit:    8'h00,
      len_op: LEN_KEEP,
      idx_op: IDX_KEEP,
      mem_wr: 1'b0,
      fin:    1'b0
   };

   // Microprogram table
   function automatic uword_type ucode_word(input logic [PC_W-1:0] step);
      uword_type w;
      w = UW_NOP;
      case (step)
         STEP_IDLE: begin
            w.jmp = JMP_DISPATCH;
         end
         STEP_RAW: begin
            w.emit = 1'b1; w.src = SRC_CHAR; w.sess = 1'b1;
            w.jmp = JMP_GOTO; w.target = STEP_FIN;
         end
         // kill line: ^U CR LF
         STEP_KILL: begin
            w.emit = 1'b1; w.lit = CHR_CARET;
         end
         STEP_KILL1: begin
            w.emit = 1'b1; w.lit = CHR_U;
         end
         STEP_KILL2: begin
            w.emit = 1'b1; w.lit = CHR_CR;
         end
         STEP_KILL3: begin
            w.emit = 1'b1; w.lit = CHR_LF; w.len_op = LEN_CLEAR;
            w.jmp = JMP_GOTO; w.target = STEP_FIN;
         end
         // retype line: ^R CR LF, then the stored bytes
         STEP_RTYP: begin
            w.emit = 1'b1; w.lit = CHR_CARET;
         end
         STEP_RTYP1: begin
            w.emit = 1'b1; w.lit = CHR_R;
         end
         STEP_RTYP2: begin
            w.emit = 1'b1; w.lit = CHR_CR;
         end
         STEP_RTYP3: begin
            w.emit = 1'b1; w.lit = CHR_LF; w.idx_op = IDX_CLEAR;
         end
         STEP_RRD: begin
            w.jmp = JMP_COND; w.cond = COND_IDX_EQ_LEN; w.target = STEP_FIN;
         end
         STEP_REMIT: begin
            w.emit = 1'b1; w.src = SRC_RDATA; w.idx_op = IDX_INC;
            w.jmp = JMP_GOTO; w.target = STEP_RRD;
         end
         // erase: BS SP BS
         STEP_ERS: begin
            w.emit = 1'b1; w.lit = CHR_BS; w.len_op = LEN_DEC;
         end
         STEP_ERS1: begin
            w.emit = 1'b1; w.lit = CHR_SPACE;
         end
         STEP_ERS2: begin
            w.emit = 1'b1; w.lit = CHR_BS;
            w.jmp = JMP_GOTO; w.target = STEP_FIN;
         end
         // end of line: CR LF, then store LF
         STEP_NL: begin
            w.emit = 1'b1; w.lit = CHR_CR;
         end
         STEP_NL1: begin
            w.emit = 1'b1; w.lit = CHR_LF;
            w.jmp = JMP_GOTO; w.target = STEP_STORE;
         end
         STEP_OTHER: begin
            w.emit = 1'b1; w.src = SRC_CHAR;
         end
         // append to line; fall into flush when due
         STEP_STORE: begin
            w.mem_wr = 1'b1; w.len_op = LEN_INC; w.idx_op = IDX_CLEAR;
            w.jmp = JMP_COND; w.cond = COND_NO_FLUSH; w.target = STEP_FIN;
         end
         STEP_FRD: begin
            w.jmp = JMP_COND; w.cond = COND_IDX_EQ_LEN; w.target = STEP_FCLR;
         end
         STEP_FEMIT: begin
            w.emit = 1'b1; w.src = SRC_RDATA; w.sess = 1'b1; w.idx_op = IDX_INC;
            w.gate = GATE_TAKEN;
            w.jmp = JMP_COND; w.cond = COND_RDATA_NZ; w.target = STEP_FRD;
         end
         STEP_FCLR: begin
            w.len_op = LEN_CLEAR;
            w.jmp = JMP_GOTO; w.target = STEP_FIN;
         end
         STEP_FIN: begin
            w.fin = 1'b1;
            w.jmp = JMP_GOTO; w.target = STEP_IDLE;
         end
         default: begin
            w.jmp = JMP_GOTO; w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // Entry step for a received byte
   function automatic logic [PC_W-1:0] dispatch_step(input logic [7:0] rx,
                                                     input logic raw,
                                                     input logic remote,
                                                     input logic empty);
      logic [PC_W-1:0] s;
      s = STEP_OTHER;
      if (raw) begin
         s = STEP_RAW;
      end else if (remote) begin
         s = STEP_STORE;
      end else begin
         case (rx[6:0])
            KEY_CTRL_U: s = empty ? STEP_FIN : STEP_KILL;
            KEY_CTRL_R: s = empty ? STEP_FIN : STEP_RTYP;
            KEY_DEL,
            KEY_BS:     s = empty ? STEP_FIN : STEP_ERS;
            KEY_CR,
            KEY_LF:     s = STEP_NL;
            default:    s = STEP_OTHER;
         endcase
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== design/lned_sequencer.sv =====
// Microprogram sequencer: step counter, control table lookup and jumps.
`default_nettype none

module lned_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_rx_byte,
   input  wire lned_pkg::status_type status,
   input  wire logic                stall,
   output lned_pkg::ctl_type        ctl
);
   import lned_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   uword_type       uw;
   logic            cond_true;
   logic            taken;
   logic            act;

   assign uw = ucode_word(pc_ff);

   // Jump condition
   always_comb begin
      case (uw.cond)
         COND_IDX_EQ_LEN: cond_true = status.idx_eq_len;
         COND_RDATA_NZ:   cond_true = status.rdata_nz;
         COND_NO_FLUSH:   cond_true = status.no_flush;
         default:         cond_true = 1'b0;
      endcase
   end

   always_comb begin
      case (uw.jmp)
         JMP_GOTO:     taken = 1'b1;
         JMP_COND:     taken = cond_true;
         JMP_DISPATCH: taken = req_valid;
         default:      taken = 1'b0;
      endcase
   end

   assign act       = (uw.gate == GATE_ALWAYS) || taken;
   assign req_ready = (uw.jmp == JMP_DISPATCH);

   // Next step
   always_comb begin
      pc_in = pc_ff;
      if (!stall) begin
         case (uw.jmp)
            JMP_NEXT:     pc_in = pc_ff + PC_W'(1);
            JMP_GOTO:     pc_in = uw.target;
            JMP_COND:     pc_in = taken ? uw.target : pc_ff + PC_W'(1);
            JMP_DISPATCH: pc_in = req_valid ? dispatch_step(req_rx_byte, status.raw_mode,
                                                            status.remote_echo,
                                                            status.line_empty)
                                            : pc_ff;
            default:      pc_in = STEP_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Gated datapath controls
   always_comb begin
      ctl.load_char = req_ready && req_valid;
      ctl.emit      = uw.emit && act;
      ctl.src       = uw.src;
      ctl.sess      = uw.sess;
      ctl.lit       = uw.lit;
      ctl.len_op    = act ? uw.len_op : LEN_KEEP;
      ctl.idx_op    = act ? uw.idx_op : IDX_KEEP;
      ctl.mem_wr    = uw.mem_wr && act;
      ctl.fin       = uw.fin && act;
   end

endmodule

`default_nettype wire

// ===== design/lned_datapath.sv =====
// Datapath: config, line store, counters, held result and output register.
`default_nettype none

module lned_datapath #(
   parameter int LINE_SIZE = lned_pkg::LINE_SIZE_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [lned_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lned_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [7:0]                    req_rx_byte,
   input  wire lned_pkg::ctl_type             ctl,
   output lned_pkg::status_type               status,
   output logic                               stall,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_to_session,
   output logic                               rsp_last_of_run
);
   import lned_pkg::*;

   localparam int LEN_W = $clog2(LINE_SIZE);

   logic             raw_ff, remote_ff;
   logic [7:0]       char_ff, char_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [6:0]       rdata_ff;
   logic [6:0]       line_mem [LINE_SIZE];
   logic [7:0]       held_byte_ff;
   logic             held_sess_ff;
   logic             held_vld_ff;
   logic             rsp_vld_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_sess_ff;
   logic             rsp_last_ff;
   logic [7:0]       emit_byte;
   logic             out_free;
   logic             push;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= 1'b0;
         remote_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RAW_MODE:    raw_ff    <= csr_wdata[0];
            CSR_REMOTE_ECHO: remote_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Received byte: masked to 7 bits unless raw; CR folded to LF with local editing only
   always_comb begin
      if (raw_ff) begin
         char_in = req_rx_byte;
      end else if (!remote_ff && (req_rx_byte[6:0] == KEY_CR)) begin
         char_in = CHR_LF;
      end else begin
         char_in = {1'b0, req_rx_byte[6:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_char) begin
         char_ff <= char_in;
      end
   end

   // Result source
   always_comb begin
      case (ctl.src)
         SRC_CHAR:  emit_byte = char_ff;
         SRC_RDATA: emit_byte = {1'b0, rdata_ff};
         default:   emit_byte = ctl.lit;
      endcase
   end

   // A new result pushes the held one out; the last one waits for the final step
   assign out_free = !rsp_vld_ff || rsp_ready;
   assign push     = (ctl.emit || ctl.fin) && held_vld_ff;
   assign stall    = push && !out_free;

   // Line length and index counters
   always_comb begin
      len_in = len_ff;
      if (!stall) begin
         case (ctl.len_op)
            LEN_CLEAR: len_in = '0;
            LEN_INC:   len_in = len_ff + LEN_W'(1);
            LEN_DEC:   len_in = len_ff - LEN_W'(1);
            default:   len_in = len_ff;
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (!stall) begin
         case (ctl.idx_op)
            IDX_CLEAR: idx_in = '0;
            IDX_INC:   idx_in = idx_ff + LEN_W'(1);
            default:   idx_in = idx_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         idx_ff <= '0;
      end else begin
         len_ff <= len_in;
         idx_ff <= idx_in;
      end
   end

   // Line store: write at the line end, registered read at the index
   always_ff @(posedge clock) begin
      if (ctl.mem_wr && !stall) begin
         line_mem[len_ff] <= char_ff[6:0];
      end
      rdata_ff <= line_mem[idx_ff];
   end

   // Held result
   always_ff @(posedge clock) begin
      if (reset) begin
         held_vld_ff <= 1'b0;
      end else if (!stall) begin
         if (ctl.emit) begin
            held_vld_ff <= 1'b1;
         end else if (ctl.fin) begin
            held_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit && !stall) begin
         held_byte_ff <= emit_byte;
         held_sess_ff <= ctl.sess;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (push && !stall) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !stall) begin
         rsp_byte_ff <= held_byte_ff;
         rsp_sess_ff <= held_sess_ff;
         rsp_last_ff <= ctl.fin;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_to_session  = rsp_sess_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // Flags for the sequencer
   always_comb begin
      status.idx_eq_len  = (idx_ff == len_ff);
      status.rdata_nz    = (rdata_ff != 7'd0);
      status.no_flush    = (len_ff < LEN_W'(LINE_SIZE - 2)) && !remote_ff &&
                           (char_ff[6:0] != KEY_LF);
      status.line_empty  = (len_ff == '0);
      status.raw_mode    = raw_ff;
      status.remote_echo = remote_ff;
   end

endmodule

`default_nettype wire

// ===== design/terminal_line_editor.sv =====
// Top level of the terminal line editor: sequencer, datapath and checks.
// A request is taken in the idle step; each result is first held, then moved into the output
// register by the next result or by the final step of the run.
// One request at a time: a new request is taken only after the final step of the last one;
// a stalled output holds the sequencer.
// Reset: synchronous, active high; clears config, line length and output valid.
`default_nettype none

module terminal_line_editor #(
   parameter int LINE_SIZE = lned_pkg::LINE_SIZE_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [lned_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lned_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_rx_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [7:0]                           rsp_out_byte,
   output logic                                 rsp_to_session,
   output logic                                 rsp_last_of_run
);
   import lned_pkg::*;

   ctl_type    ctl;
   status_type status;
   logic       stall;

   lned_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .status      (status),
      .stall       (stall),
      .ctl         (ctl)
   );

   lned_datapath #(
      .LINE_SIZE (LINE_SIZE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_rx_byte     (req_rx_byte),
      .ctl             (ctl),
      .status          (status),
      .stall           (stall),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_to_session  (rsp_to_session),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // The sequencer only waits on a full, unread output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      stall |-> (rsp_valid && !rsp_ready))
      else $error("sequencer stalled with output register free");

   // Raw bytes never reach the line store
   a_raw_no_store: assert property (@(posedge clock) disable iff (reset)
      ctl.mem_wr |-> !status.raw_mode)
      else $error("line store written in raw mode");

   // A raw request goes straight to the session path
   a_raw_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.raw_mode) |=>
         (ctl.emit && ctl.sess && (ctl.src == SRC_CHAR)))
      else $error("raw request not sent to session");

   // The sequencer never stalls while it waits for a request
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !stall)
      else $error("stall while waiting for a request");

endmodule

`default_nettype wire
